FILE: rtl/core/utf8_stream_decoder_defines.svh
// Assertion macros shared by the decoder modules.
`ifndef UTF8_STREAM_DECODER_DEFINES_SVH
`define UTF8_STREAM_DECODER_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define U8SD_ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("u8sd: same-cycle check failed");

// Next-cycle implication, checked out of reset.
`define U8SD_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("u8sd: next-cycle check failed");

`endif

FILE: rtl/core/u8sd_pkg.sv
`default_nettype none
package u8sd_pkg;

    localparam int CP_W = 21;
    localparam logic [CP_W-1:0] REPL_CP = 21'h00FFFD;

    localparam logic [2:0] LEN_NONE = 3'd0;
    localparam logic [2:0] LEN_2    = 3'd2;
    localparam logic [2:0] LEN_3    = 3'd3;
    localparam logic [2:0] LEN_4    = 3'd4;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic            eob;
        logic            has_cp;
        logic [2:0]      n_rep;
        logic [CP_W-1:0] cp;
    } job_t;

endpackage
`default_nettype wire

FILE: rtl/core/u8sd_front.sv
`default_nettype none
`include "utf8_stream_decoder_defines.svh"
module u8sd_front (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          accept_i,
    input  wire logic [7:0]    data_byte_i,
    input  wire logic          eob_i,
    output u8sd_pkg::job_t     job_o,
    output logic               push_o
);

    logic [2:0]  len_reg, len_next;
    logic [1:0]  held_reg, held_next;
    logic [20:0] acc_reg, acc_next;
    logic [1:0]  held_inc;
    logic [20:0] acc_shift;
    logic        is_cont;
    logic        do_fresh;
    logic        job_nonempty;
    logic        job_fits;
    u8sd_pkg::job_t job;

    assign is_cont   = (data_byte_i[7:6] == 2'b10);
    assign held_inc  = held_reg + 2'd1;
    assign acc_shift = {acc_reg[14:0], data_byte_i[5:0]};

    always_comb begin
        job       = '0;
        job.eob   = eob_i;
        len_next  = len_reg;
        held_next = held_reg;
        acc_next  = acc_reg;
        do_fresh  = 1'b0;
        if (len_reg != u8sd_pkg::LEN_NONE) begin
            if (is_cont) begin
                acc_next  = acc_shift;
                held_next = held_inc;
                if (({1'b0, held_inc} + 3'd1) >= len_reg) begin
                    job.has_cp = 1'b1;
                    job.cp     = acc_shift;
                    len_next   = u8sd_pkg::LEN_NONE;
                    held_next  = '0;
                    acc_next   = '0;
                end else if (eob_i) begin
                    job.n_rep = {1'b0, held_inc} + 3'd1;
                    len_next  = u8sd_pkg::LEN_NONE;
                    held_next = '0;
                    acc_next  = '0;
                end
            end else begin
                job.n_rep = {1'b0, held_reg} + 3'd1;
                len_next  = u8sd_pkg::LEN_NONE;
                held_next = '0;
                acc_next  = '0;
                do_fresh  = 1'b1;
            end
        end else begin
            do_fresh = 1'b1;
        end
        if (do_fresh) begin
            if (!data_byte_i[7]) begin
                job.has_cp = 1'b1;
                job.cp     = {13'd0, data_byte_i};
            end else if (is_cont || data_byte_i[7:3] == 5'b11111) begin
                job.n_rep = job.n_rep + 3'd1;
            end else if (eob_i) begin
                job.n_rep = job.n_rep + 3'd1;
            end else begin
                held_next = '0;
                if (!data_byte_i[5]) begin
                    len_next = u8sd_pkg::LEN_2;
                    acc_next = {16'd0, data_byte_i[4:0]};
                end else if (!data_byte_i[4]) begin
                    len_next = u8sd_pkg::LEN_3;
                    acc_next = {17'd0, data_byte_i[3:0]};
                end else begin
                    len_next = u8sd_pkg::LEN_4;
                    acc_next = {18'd0, data_byte_i[2:0]};
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg  <= u8sd_pkg::LEN_NONE;
            held_reg <= '0;
            acc_reg  <= '0;
        end else if (accept_i) begin
            len_reg  <= len_next;
            held_reg <= held_next;
            acc_reg  <= acc_next;
        end
    end

    assign job_nonempty = (job.n_rep != 3'd0) || job.has_cp;
    assign job_fits     = (job.n_rep + {2'd0, job.has_cp}) <= 3'd4;
    assign push_o       = accept_i && job_nonempty;
    assign job_o        = job;

    `U8SD_ASSERT_NEXT(a_eob_closes, aclk, aresetn, accept_i && eob_i, len_reg == u8sd_pkg::LEN_NONE)
    `U8SD_ASSERT_IMPL(a_eob_gives_result, aclk, aresetn, accept_i && eob_i, push_o && job_fits)

endmodule
`default_nettype wire

FILE: rtl/core/u8sd_queue.sv
`default_nettype none
`include "utf8_stream_decoder_defines.svh"
module u8sd_queue (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           push_i,
    input  wire u8sd_pkg::job_t job_i,
    input  wire logic           pop_i,
    output u8sd_pkg::job_t      head_o,
    output logic                empty_o,
    output logic                full_o
);

    localparam int AW = u8sd_pkg::QUEUE_AW;
    localparam int CW = u8sd_pkg::QUEUE_CW;

    u8sd_pkg::job_t entry_reg [u8sd_pkg::QUEUE_DEPTH];
    logic [AW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]  count_reg, count_next;

    assign empty_o = (count_reg == '0);
    assign full_o  = (count_reg == CW'(u8sd_pkg::QUEUE_DEPTH));
    assign head_o  = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push_i ? wr_ptr_reg + AW'(1) : wr_ptr_reg;
        rd_ptr_next = pop_i  ? rd_ptr_reg + AW'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push_i && !pop_i) begin
            count_next = count_reg + CW'(1);
        end else if (pop_i && !push_i) begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push_i) begin
            entry_reg[wr_ptr_reg] <= job_i;
        end
    end

    `U8SD_ASSERT_IMPL(a_pop_has_entry, aclk, aresetn, pop_i, !empty_o)

endmodule
`default_nettype wire

FILE: rtl/core/u8sd_back.sv
`default_nettype none
`include "utf8_stream_decoder_defines.svh"
module u8sd_back (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire u8sd_pkg::job_t head_i,
    input  wire logic           head_valid_i,
    output logic                pop_o,
    output logic                m_tvalid,
    input  wire logic           m_tready,
    output logic [23:0]         m_tdata,
    output logic                m_tlast,
    output logic [1:0]          m_tuser
);

    logic [2:0]  idx_reg, idx_next;
    logic        m_tvalid_reg, m_tvalid_next;
    logic [20:0] cp_reg;
    logic        replaced_reg;
    logic        last_reg;
    logic        done_reg;
    logic [2:0]  total;
    logic        is_rep;
    logic        is_last;
    logic        load;
    logic        idx_in_range;

    assign total        = head_i.n_rep + {2'd0, head_i.has_cp};
    assign is_rep       = idx_reg < head_i.n_rep;
    assign is_last      = (idx_reg + 3'd1) == total;
    assign idx_in_range = idx_reg < total;
    assign load         = head_valid_i && (!m_tvalid_reg || m_tready);
    assign pop_o        = load && is_last;

    always_comb begin
        idx_next      = idx_reg;
        m_tvalid_next = m_tvalid_reg;
        if (load) begin
            idx_next      = is_last ? 3'd0 : idx_reg + 3'd1;
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            idx_reg      <= idx_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            cp_reg       <= is_rep ? u8sd_pkg::REPL_CP : head_i.cp;
            replaced_reg <= is_rep;
            last_reg     <= is_last;
            done_reg     <= is_last && head_i.eob;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {3'd0, cp_reg};
    assign m_tlast  = last_reg;
    assign m_tuser  = {done_reg, replaced_reg};

    `U8SD_ASSERT_IMPL(a_idx_in_job, aclk, aresetn, head_valid_i, idx_in_range)
    `U8SD_ASSERT_NEXT(a_pop_marks_last, aclk, aresetn, pop_o, m_tvalid_reg && last_reg)

endmodule
`default_nettype wire

FILE: rtl/core/utf8_stream_decoder.sv
// UTF-8 byte stream to code point decoder.
// Slave channel: one raw byte per transaction on s_tdata, s_tlast marking the final
// byte of a buffer; any sequence still open at that byte is flushed.
// Master channel: one code point per transaction on m_tdata; m_tuser[0] flags a
// U+FFFD that replaces malformed input, m_tuser[1] flags the final code point of the
// buffer, m_tlast marks the last code point caused by one input byte.
// A byte may cause no code point (lead or inner continuation) or up to four
// (a broken sequence flushed as U+FFFD per held byte, then the byte itself).
// Throughput: one byte per cycle while the queue has room; a byte's code points
// take the output register in turn. Path: queue entry, then output register.
// The classifier takes a byte every cycle while its four-entry job queue has room;
// the output stage drains one code point per cycle from the queue head unless stalled.
// m_tready low stalls only the output stage; the classifier keeps taking bytes
// until the queue fills, then drops s_tready.
// Reset (aresetn low, synchronous) closes any open sequence, empties the queue and
// clears m_tvalid.
`default_nettype none
module utf8_stream_decoder (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] data_byte
    input  wire logic        s_tlast,   // end_of_buffer
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata,   // [20:0] code_point, [23:21] zero
    output logic             m_tlast,   // run_last
    output logic [1:0]       m_tuser    // [0] replaced, [1] buffer_done
);

    logic           accept;
    logic           push;
    logic           pop;
    logic           q_empty;
    logic           q_full;
    u8sd_pkg::job_t front_job;
    u8sd_pkg::job_t head_job;

    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;

    u8sd_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .accept_i    (accept),
        .data_byte_i (s_tdata),
        .eob_i       (s_tlast),
        .job_o       (front_job),
        .push_o      (push)
    );

    u8sd_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push_i  (push),
        .job_i   (front_job),
        .pop_i   (pop),
        .head_o  (head_job),
        .empty_o (q_empty),
        .full_o  (q_full)
    );

    u8sd_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .head_i       (head_job),
        .head_valid_i (!q_empty),
        .pop_o        (pop),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tlast      (m_tlast),
        .m_tuser      (m_tuser)
    );

endmodule
`default_nettype wire
